/* rtl/omc_pkg.sv */
package omc_pkg;

	// Default timer width in bits (legal range 8 to 16)
	localparam int TIMER_WIDTH_DEF = 10;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_SAMPLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_TAIL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_RECOVERY   = 3'd5;

	// Register reset values
	localparam logic [9:0] RESET_LOW_DEF       = 10'd500;
	localparam logic [9:0] PRESENCE_SAMPLE_DEF = 10'd65;
	localparam logic [9:0] PRESENCE_TAIL_DEF   = 10'd240;
	localparam logic [7:0] READ_LOW_DEF        = 8'd14;
	localparam logic [7:0] READ_SAMPLE_DEF     = 8'd7;
	localparam logic [7:0] READ_RECOVERY_DEF   = 8'd100;

	// Fixed slot timing in microseconds
	localparam logic [9:0] RELEASE_CHECK_TIME = 10'd5;
	localparam logic [9:0] WRITE_SLOT_TIME    = 10'd10;
	localparam logic [9:0] WRITE_HOLD_TIME    = 10'd50;

	// Opcodes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_RESET = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_DEVICE = 2'd1;
	localparam logic [1:0] ST_LINE_LOW  = 2'd2;
	localparam logic [1:0] ST_MISMATCH  = 2'd3;

	typedef struct packed {
		logic [9:0] reset_low_time;
		logic [9:0] presence_sample_time;
		logic [9:0] presence_tail_time;
		logic [7:0] read_low_time;
		logic [7:0] read_sample_time;
		logic [7:0] read_recovery_time;
	} cfg_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       line_select;
		logic [7:0] write_byte;
		logic       sample_a;
		logic       sample_b;
	} item_t;

	typedef struct packed {
		logic       drive_low_a;
		logic       drive_low_b;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] read_data;
	} res_t;

	typedef enum logic [11:0] {
		PH_IDLE     = 12'b0000_0000_0001,
		PH_RST_LOW  = 12'b0000_0000_0010,
		PH_RST_GAP  = 12'b0000_0000_0100,
		PH_RST_WAIT = 12'b0000_0000_1000,
		PH_RST_TAIL = 12'b0000_0001_0000,
		PH_W_LOW    = 12'b0000_0010_0000,
		PH_W_SET    = 12'b0000_0100_0000,
		PH_W_HOLD   = 12'b0000_1000_0000,
		PH_W_REL    = 12'b0001_0000_0000,
		PH_R_LOW    = 12'b0010_0000_0000,
		PH_R_WAIT   = 12'b0100_0000_0000,
		PH_R_REC    = 12'b1000_0000_0000
	} phase_t;

endpackage

/* rtl/omc_cfg_regs.sv */
module omc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [omc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [omc_pkg::CFG_DATA_W-1:0]  wr_data,
	output omc_pkg::cfg_t                   cfg
);

	omc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_time       <= omc_pkg::RESET_LOW_DEF;
			cfg_q.presence_sample_time <= omc_pkg::PRESENCE_SAMPLE_DEF;
			cfg_q.presence_tail_time   <= omc_pkg::PRESENCE_TAIL_DEF;
			cfg_q.read_low_time        <= omc_pkg::READ_LOW_DEF;
			cfg_q.read_sample_time     <= omc_pkg::READ_SAMPLE_DEF;
			cfg_q.read_recovery_time   <= omc_pkg::READ_RECOVERY_DEF;
		end else if (wr_en) begin
			case (wr_index)
				omc_pkg::CFG_RESET_LOW:       cfg_q.reset_low_time       <= wr_data;
				omc_pkg::CFG_PRESENCE_SAMPLE: cfg_q.presence_sample_time <= wr_data;
				omc_pkg::CFG_PRESENCE_TAIL:   cfg_q.presence_tail_time   <= wr_data;
				omc_pkg::CFG_READ_LOW:        cfg_q.read_low_time        <= wr_data[7:0];
				omc_pkg::CFG_READ_SAMPLE:     cfg_q.read_sample_time     <= wr_data[7:0];
				omc_pkg::CFG_READ_RECOVERY:   cfg_q.read_recovery_time   <= wr_data[7:0];
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/omc_seq.sv */
module omc_seq #(
	parameter int TIMER_WIDTH = omc_pkg::TIMER_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  omc_pkg::item_t item,
	input  omc_pkg::cfg_t  cfg,
	output omc_pkg::res_t  res
);

	localparam int CW = (TIMER_WIDTH > 10) ? TIMER_WIDTH : 10;
	localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};
	localparam logic [TIMER_WIDTH-1:0] TONE = TIMER_WIDTH'(1);

	omc_pkg::phase_t        phase_q, phase_n;
	logic [TIMER_WIDTH-1:0] tc_q, tc_n, tc_inc, ptime;
	logic [2:0]             bit_q, bit_n;
	logic [7:0]             shift_q, shift_n;
	logic                   line_q, line_n;
	logic [9:0]             raw_time;
	logic                   smp, cur_bit, drv, done, slot_end;
	logic [1:0]             status;
	logic [7:0]             rdata;

	// Phase length, zero acts as one, saturate at the timer range
	always_comb begin
		case (phase_q)
			omc_pkg::PH_RST_LOW:  raw_time = cfg.reset_low_time;
			omc_pkg::PH_RST_GAP:  raw_time = omc_pkg::RELEASE_CHECK_TIME;
			omc_pkg::PH_RST_WAIT: raw_time = cfg.presence_sample_time;
			omc_pkg::PH_RST_TAIL: raw_time = cfg.presence_tail_time;
			omc_pkg::PH_W_LOW:    raw_time = omc_pkg::WRITE_SLOT_TIME;
			omc_pkg::PH_W_SET:    raw_time = omc_pkg::WRITE_SLOT_TIME;
			omc_pkg::PH_W_HOLD:   raw_time = omc_pkg::WRITE_HOLD_TIME;
			omc_pkg::PH_W_REL:    raw_time = omc_pkg::WRITE_HOLD_TIME;
			omc_pkg::PH_R_LOW:    raw_time = {2'b00, cfg.read_low_time};
			omc_pkg::PH_R_WAIT:   raw_time = {2'b00, cfg.read_sample_time};
			omc_pkg::PH_R_REC:    raw_time = {2'b00, cfg.read_recovery_time};
			default:              raw_time = 10'd1;
		endcase
		if (raw_time == 10'd0)
			ptime = TONE;
		else if (CW'(raw_time) > CW'(TMAX))
			ptime = TMAX;
		else
			ptime = TIMER_WIDTH'(raw_time);
	end

	assign smp      = line_q ? item.sample_b : item.sample_a;
	assign cur_bit  = shift_q[bit_q];
	assign tc_inc   = (tc_q == TMAX) ? tc_q : tc_q + TONE;
	assign slot_end = (tc_inc >= ptime);

	always_comb begin
		phase_n = phase_q;
		tc_n    = tc_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		line_n  = line_q;
		done    = 1'b0;
		status  = omc_pkg::ST_OK;
		rdata   = 8'd0;
		if (phase_q == omc_pkg::PH_IDLE) begin
			if (item.opcode != omc_pkg::OP_TICK) begin
				line_n  = item.line_select;
				bit_n   = 3'd0;
				tc_n    = '0;
				shift_n = (item.opcode == omc_pkg::OP_WRITE) ? item.write_byte : 8'd0;
				case (item.opcode)
					omc_pkg::OP_RESET: phase_n = omc_pkg::PH_RST_LOW;
					omc_pkg::OP_WRITE: phase_n = omc_pkg::PH_W_LOW;
					default:           phase_n = omc_pkg::PH_R_LOW;
				endcase
			end
		end else begin
			tc_n = tc_inc;
			if (slot_end) begin
				tc_n = '0;
				case (phase_q)
					omc_pkg::PH_RST_LOW: phase_n = omc_pkg::PH_RST_GAP;
					omc_pkg::PH_RST_GAP: begin
						if (!smp) begin
							phase_n = omc_pkg::PH_IDLE;
							done    = 1'b1;
							status  = omc_pkg::ST_LINE_LOW;
						end else begin
							phase_n = omc_pkg::PH_RST_WAIT;
						end
					end
					omc_pkg::PH_RST_WAIT: begin
						shift_n = {7'd0, ~smp};
						phase_n = omc_pkg::PH_RST_TAIL;
					end
					omc_pkg::PH_RST_TAIL: begin
						phase_n = omc_pkg::PH_IDLE;
						done    = 1'b1;
						status  = shift_q[0] ? omc_pkg::ST_OK : omc_pkg::ST_NO_DEVICE;
					end
					omc_pkg::PH_W_LOW: phase_n = omc_pkg::PH_W_SET;
					omc_pkg::PH_W_SET: begin
						if (smp != cur_bit) begin
							phase_n = omc_pkg::PH_IDLE;
							done    = 1'b1;
							status  = omc_pkg::ST_MISMATCH;
						end else begin
							phase_n = omc_pkg::PH_W_HOLD;
						end
					end
					omc_pkg::PH_W_HOLD: phase_n = omc_pkg::PH_W_REL;
					omc_pkg::PH_W_REL: begin
						if (bit_q == 3'd7) begin
							phase_n = omc_pkg::PH_IDLE;
							done    = 1'b1;
						end else begin
							bit_n   = bit_q + 3'd1;
							phase_n = omc_pkg::PH_W_LOW;
						end
					end
					omc_pkg::PH_R_LOW: phase_n = omc_pkg::PH_R_WAIT;
					omc_pkg::PH_R_WAIT: begin
						shift_n = shift_q | (8'(smp) << bit_q);
						phase_n = omc_pkg::PH_R_REC;
					end
					omc_pkg::PH_R_REC: begin
						if (bit_q == 3'd7) begin
							phase_n = omc_pkg::PH_IDLE;
							done    = 1'b1;
							rdata   = shift_q;
						end else begin
							bit_n   = bit_q + 3'd1;
							phase_n = omc_pkg::PH_R_LOW;
						end
					end
					default: phase_n = omc_pkg::PH_IDLE;
				endcase
			end
		end
	end

	// Line drive for the coming microsecond follows the new phase
	always_comb begin
		case (phase_n)
			omc_pkg::PH_RST_LOW,
			omc_pkg::PH_W_LOW,
			omc_pkg::PH_R_LOW:  drv = 1'b1;
			omc_pkg::PH_W_SET,
			omc_pkg::PH_W_HOLD: drv = ~shift_n[bit_n];
			default:            drv = 1'b0;
		endcase
	end

	assign res.drive_low_a = drv & ~line_n;
	assign res.drive_low_b = drv & line_n;
	assign res.busy_res    = (phase_n != omc_pkg::PH_IDLE);
	assign res.done_res    = done;
	assign res.status      = status;
	assign res.read_data   = rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= omc_pkg::PH_IDLE;
			tc_q    <= '0;
			bit_q   <= 3'd0;
			shift_q <= 8'd0;
			line_q  <= 1'b0;
		end else if (en) begin
			phase_q <= phase_n;
			tc_q    <= tc_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			line_q  <= line_n;
		end
	end

endmodule

/* rtl/onewire_master_controller.sv */
// Two-line 1-Wire bus master. Every input beat is one microsecond tick: it
// carries the sampled levels of lines A and B and an optional command
// (reset/presence, write byte, read byte) which is taken only while no
// command is running; a command beat that arrives while busy is ignored and
// treated as a plain tick. Every input beat yields exactly one output beat
// with the line drive for the next microsecond, busy, done, status and the
// read byte. Throughput is one beat per clock cycle while the receiver does
// not stall. An accepted input beat waits in the input register, which
// feeds the single pass through the phase sequencer, and the result register
// catches its outcome and offers it. The output register decouples the
// sides, so a new input beat is still taken while a finished result waits,
// as long as the input register is empty. Configuration registers are
// written through the cfg channel, which is always ready; write them only
// while no command is in progress. No clearing pass runs after reset.
module onewire_master_controller #(
	parameter int TIMER_WIDTH = omc_pkg::TIMER_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,

	// Input tick channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      opcode,
	input  logic                            line_select,
	input  logic [7:0]                      write_byte,
	input  logic                            sample_a,
	input  logic                            sample_b,

	// Result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            drive_low_a,
	output logic                            drive_low_b,
	output logic                            busy_res,
	output logic                            done_res,
	output logic [1:0]                      status,
	output logic [7:0]                      read_data,

	// Configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [omc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [omc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	omc_pkg::cfg_t  cfg;
	omc_pkg::item_t item_s1;
	omc_pkg::res_t  res_comb, res_q;
	logic           valid_s1, out_valid_q, advance;

	// Registers are always free to take a write
	assign cfg_ready = 1'b1;

	omc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Move the held tick into the result register when that slot is empty
	// or its beat is being taken this cycle.
	assign advance  = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~advance;

	// Input register: hold the tick until it is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.opcode      <= opcode;
			item_s1.line_select <= line_select;
			item_s1.write_byte  <= write_byte;
			item_s1.sample_a    <= sample_a;
			item_s1.sample_b    <= sample_b;
		end
	end

	// Phase sequencer: the state advances only when a tick is processed
	omc_seq #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_comb)
	);

	// Result register: hold the beat while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_comb;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_low_a = res_q.drive_low_a;
	assign drive_low_b = res_q.drive_low_b;
	assign busy_res    = res_q.busy_res;
	assign done_res    = res_q.done_res;
	assign status      = res_q.status;
	assign read_data   = res_q.read_data;

endmodule

/* rtl/omc_checker.sv */
module omc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       drive_low_a,
	input logic       drive_low_b,
	input logic       busy_res,
	input logic       done_res,
	input logic [1:0] status,
	input logic [7:0] read_data
);

	// Only the active line is ever pulled low
	a_one_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(drive_low_a && drive_low_b))
		else $error("both bus lines driven low");

	// Finishing a command leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	// Status and read byte are quiet outside the done beat
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> status == omc_pkg::ST_OK && read_data == 8'd0)
		else $error("status or read data set without done");

	// Released bus when no command runs
	a_idle_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> !drive_low_a && !drive_low_b)
		else $error("line driven while idle");

	// A stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(drive_low_a)
			&& $stable(drive_low_b) && $stable(done_res) && $stable(read_data))
		else $error("stalled result beat changed");

endmodule

bind onewire_master_controller omc_checker u_omc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.drive_low_a (drive_low_a),
	.drive_low_b (drive_low_b),
	.busy_res    (busy_res),
	.done_res    (done_res),
	.status      (status),
	.read_data   (read_data)
);
